>>> src/sreu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sreu_pkg
// shared types and constants of the small risc execute unit
// ----------------------------------------------------------------------------
package sreu_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDREG,
        ST_EXEC,
        ST_MEMRD,
        ST_MEMWAIT,
        ST_MEMWR,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

    localparam logic [7:0] OP_NOP  = 8'd0;
    localparam logic [7:0] OP_LDB  = 8'd16;
    localparam logic [7:0] OP_LDH  = 8'd17;
    localparam logic [7:0] OP_LDW  = 8'd18;
    localparam logic [7:0] OP_LSB  = 8'd20;
    localparam logic [7:0] OP_LSH  = 8'd21;
    localparam logic [7:0] OP_LSW  = 8'd22;
    localparam logic [7:0] OP_STB  = 8'd24;
    localparam logic [7:0] OP_STH  = 8'd25;
    localparam logic [7:0] OP_STW  = 8'd26;
    localparam logic [7:0] OP_LDBI = 8'd32;
    localparam logic [7:0] OP_LDHI = 8'd33;
    localparam logic [7:0] OP_LDWI = 8'd34;
    localparam logic [7:0] OP_LSBI = 8'd36;
    localparam logic [7:0] OP_LSHI = 8'd37;
    localparam logic [7:0] OP_LSWI = 8'd38;
    localparam logic [7:0] OP_STBI = 8'd40;
    localparam logic [7:0] OP_STHI = 8'd41;
    localparam logic [7:0] OP_STWI = 8'd42;
    localparam logic [7:0] OP_ADD  = 8'd48;
    localparam logic [7:0] OP_SUB  = 8'd49;
    localparam logic [7:0] OP_AND  = 8'd50;
    localparam logic [7:0] OP_ORR  = 8'd51;
    localparam logic [7:0] OP_XOR  = 8'd52;
    localparam logic [7:0] OP_NOT  = 8'd53;
    localparam logic [7:0] OP_NEG  = 8'd54;
    localparam logic [7:0] OP_LSL  = 8'd55;
    localparam logic [7:0] OP_LSR  = 8'd56;
    localparam logic [7:0] OP_MUL  = 8'd57;
    localparam logic [7:0] OP_SMUL = 8'd58;
    localparam logic [7:0] OP_MOD  = 8'd59;
    localparam logic [7:0] OP_SMOD = 8'd60;
    localparam logic [7:0] OP_DIV  = 8'd61;
    localparam logic [7:0] OP_SDIV = 8'd62;
    localparam logic [7:0] OP_ADDI = 8'd64;
    localparam logic [7:0] OP_SUBI = 8'd65;
    localparam logic [7:0] OP_ANDI = 8'd66;
    localparam logic [7:0] OP_ORRI = 8'd67;
    localparam logic [7:0] OP_XORI = 8'd68;
    localparam logic [7:0] OP_LSLI = 8'd71;
    localparam logic [7:0] OP_LSRI = 8'd72;
    localparam logic [7:0] OP_MULI = 8'd73;
    localparam logic [7:0] OP_SMULI = 8'd74;
    localparam logic [7:0] OP_MODI = 8'd75;
    localparam logic [7:0] OP_SMODI = 8'd76;
    localparam logic [7:0] OP_DIVI = 8'd77;
    localparam logic [7:0] OP_SDIVI = 8'd78;
    localparam logic [7:0] OP_JMP  = 8'd80;
    localparam logic [7:0] OP_JME  = 8'd81;
    localparam logic [7:0] OP_JNE  = 8'd82;
    localparam logic [7:0] OP_JLT  = 8'd83;
    localparam logic [7:0] OP_JGT  = 8'd84;
    localparam logic [7:0] OP_JSME = 8'd97;
    localparam logic [7:0] OP_JSNE = 8'd98;
    localparam logic [7:0] OP_JSLT = 8'd99;
    localparam logic [7:0] OP_JSGT = 8'd100;
    localparam logic [7:0] OP_MOV  = 8'd112;
    localparam logic [7:0] OP_CAL  = 8'd160;
    localparam logic [7:0] OP_CAR  = 8'd161;
    localparam logic [7:0] OP_LEA  = 8'd162;
    localparam logic [7:0] OP_RET  = 8'd176;
    localparam logic [7:0] OP_INT  = 8'd192;
    localparam logic [7:0] OP_RINT = 8'd193;
    localparam logic [7:0] OP_POPI = 8'd194;
    localparam logic [7:0] OP_PSHI = 8'd195;
    localparam logic [7:0] OP_CSR  = 8'd240;

    localparam logic [3:0] LINK_REG = 4'd15;

endpackage

>>> src/sreu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sreu_div
// radix-2 restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sreu_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sreu_pkg::div_req_t req,
    output sreu_pkg::div_rsp_t rsp
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("divider done without busy");
    a_cnt_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !req.start) |-> cnt_reg != 6'd0) else $error("divider count underflow");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg) else $error("divider failed to start");

endmodule

>>> src/small_risc_execute_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_risc_execute_unit_top
// execute unit of a 16 register 32-bit risc with register file, pc and data store
// ----------------------------------------------------------------------------
// One instruction at a time. Register file and byte data store are synchronous
// memories; a register instruction passes register read, execute and the result
// register from transfer to result, loads add a store read and a wait state per
// byte (1 to 4 bytes through the single data store port), stores a write state
// per byte, and divide or modulo with a nonzero divisor waits for the bit-serial
// divider. The result register holds until taken; the next instruction is
// taken once the result has been transferred. After reset a pass over all 16
// entries clears the register file before the first transfer. Data store bytes
// never written read back as undefined.
module small_risc_execute_unit_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_opcode,
    input  logic [3:0]  s_src_reg,
    input  logic [3:0]  s_dst_reg,
    input  logic [15:0] s_immediate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_reg_written,
    output logic [3:0]  m_written_reg,
    output logic [31:0] m_written_value,
    output logic        m_mem_written,
    output logic        m_invalid_op,
    output logic        m_divide_by_zero
);

    localparam int AW = sreu_pkg::MEM_AW;

    sreu_pkg::state_t state_reg, state_next;

    logic [31:0] rf_mem [16];
    logic [31:0] rs_q, rd_q, r15_q;
    logic        rf_we;
    logic [3:0]  rf_wa;
    logic [31:0] rf_wd;

    logic [7:0]  dm_mem [sreu_pkg::MEM_BYTES];
    logic [7:0]  dm_q;
    logic        dm_we;
    logic [AW-1:0] dm_addr;
    logic [7:0]  dm_wd;

    // register file reset by clearing pass over 16 entries
    logic        clr_reg, clr_next;
    logic [3:0]  clr_idx_reg, clr_idx_next;

    logic [7:0]  op_reg, op_next;
    logic [3:0]  s_reg, s_next, d_reg, d_next;
    logic [15:0] im_reg, im_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] addr_reg, addr_next;
    logic [2:0]  nb_reg, nb_next;
    logic [2:0]  bi_reg, bi_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] st_reg, st_next;

    logic        ov_reg, ov_next;
    logic [31:0] onpc_reg, onpc_next;
    logic        owr_reg, owr_next;
    logic [3:0]  oreg_reg, oreg_next;
    logic [31:0] oval_reg, oval_next;
    logic        omw_reg, omw_next;
    logic        oinv_reg, oinv_next;
    logic        odz_reg, odz_next;
    logic        is_mod_reg, is_mod_next;

    sreu_pkg::div_req_t dreq;
    sreu_pkg::div_rsp_t drsp;

    logic [31:0] simm, uim, sh_amt_rd, npc2, npc4, npcb;
    logic [31:0] pl;
    logic        is_ld, is_st, ld_sx;
    logic [31:0] mem_base;
    logic [63:0] mprod;

    sreu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_wa] <= rf_wd;
        end
        rs_q  <= rf_mem[s_reg];
        rd_q  <= rf_mem[d_reg];
        r15_q <= rf_mem[sreu_pkg::LINK_REG];
    end

    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dm_mem[dm_addr] <= dm_wd;
        end
        dm_q <= dm_mem[dm_addr];
    end

    always_comb begin
        simm = {{16{im_reg[15]}}, im_reg};
        uim  = {16'd0, im_reg};
        sh_amt_rd = rd_q;
        npc2 = pc_reg + 32'd2;
        npc4 = pc_reg + 32'd4;
        npcb = pc_reg + simm;
        pl   = {{8{s_reg[3]}}, s_reg, d_reg, im_reg};
        mprod = rs_q * ((op_reg == sreu_pkg::OP_MUL) ? rd_q : uim);
        is_ld = 1'b0;
        is_st = 1'b0;
        ld_sx = 1'b0;
        nb_next = nb_reg;
        unique case (op_reg)
            sreu_pkg::OP_LDB, sreu_pkg::OP_LDBI: begin is_ld = 1'b1; nb_next = 3'd1; end
            sreu_pkg::OP_LDH, sreu_pkg::OP_LDHI: begin is_ld = 1'b1; nb_next = 3'd2; end
            sreu_pkg::OP_LDW, sreu_pkg::OP_LDWI,
            sreu_pkg::OP_LSW, sreu_pkg::OP_LSWI: begin is_ld = 1'b1; nb_next = 3'd4; end
            sreu_pkg::OP_LSB, sreu_pkg::OP_LSBI: begin
                is_ld = 1'b1; ld_sx = 1'b1; nb_next = 3'd1;
            end
            sreu_pkg::OP_LSH, sreu_pkg::OP_LSHI: begin
                is_ld = 1'b1; ld_sx = 1'b1; nb_next = 3'd2;
            end
            sreu_pkg::OP_STB, sreu_pkg::OP_STBI: begin is_st = 1'b1; nb_next = 3'd1; end
            sreu_pkg::OP_STH, sreu_pkg::OP_STHI: begin is_st = 1'b1; nb_next = 3'd2; end
            sreu_pkg::OP_STW, sreu_pkg::OP_STWI: begin is_st = 1'b1; nb_next = 3'd4; end
            default: ;
        endcase
        if (op_reg[5]) begin
            mem_base = (is_st ? rd_q : rs_q) + simm;
        end else begin
            mem_base = is_st ? rd_q : rs_q;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        op_next  = op_reg;
        s_next   = s_reg;
        d_next   = d_reg;
        im_next  = im_reg;
        pc_next  = pc_reg;
        addr_next = addr_reg;
        bi_next  = bi_reg;
        acc_next = acc_reg;
        st_next  = st_reg;
        ov_next  = ov_reg;
        onpc_next = onpc_reg;
        owr_next = owr_reg;
        oreg_next = oreg_reg;
        oval_next = oval_reg;
        omw_next = omw_reg;
        oinv_next = oinv_reg;
        odz_next = odz_reg;
        is_mod_next = is_mod_reg;
        rf_we = 1'b0;
        rf_wa = oreg_reg;
        rf_wd = oval_reg;
        dm_we = 1'b0;
        dm_addr = addr_reg[AW-1:0];
        dm_wd = st_reg[31:24];
        dreq.start = 1'b0;
        dreq.dividend = rs_q;
        dreq.divisor = (op_reg == sreu_pkg::OP_MOD || op_reg == sreu_pkg::OP_DIV) ? rd_q : uim;
        s_ready = 1'b0;

        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            sreu_pkg::ST_IDLE: begin
                if (clr_reg) begin
                    rf_we = 1'b1;
                    rf_wa = clr_idx_reg;
                    rf_wd = '0;
                    clr_idx_next = clr_idx_reg + 4'd1;
                    if (clr_idx_reg == 4'd15) begin
                        clr_next = 1'b0;
                    end
                end else begin
                    s_ready = !ov_reg;
                    if (s_valid && !ov_reg) begin
                        op_next = s_opcode;
                        s_next  = s_src_reg;
                        d_next  = s_dst_reg;
                        im_next = s_immediate;
                        state_next = sreu_pkg::ST_RDREG;
                    end
                end
            end
            sreu_pkg::ST_RDREG: begin
                state_next = sreu_pkg::ST_EXEC;
            end
            sreu_pkg::ST_EXEC: begin
                owr_next  = 1'b0;
                oreg_next = '0;
                oval_next = '0;
                omw_next  = 1'b0;
                oinv_next = 1'b0;
                odz_next  = 1'b0;
                onpc_next = npc2;
                state_next = sreu_pkg::ST_DONE;
                addr_next = mem_base;
                bi_next = '0;
                acc_next = '0;
                unique case (nb_next)
                    3'd1: st_next = {rs_q[7:0], 24'd0};
                    3'd2: st_next = {rs_q[15:0], 16'd0};
                    default: st_next = rs_q;
                endcase
                if (op_reg[5] && (is_ld || is_st)) begin
                    onpc_next = npc4;
                end
                if (is_ld) begin
                    owr_next = 1'b1;
                    oreg_next = d_reg;
                    state_next = sreu_pkg::ST_MEMRD;
                end else if (is_st) begin
                    omw_next = 1'b1;
                    state_next = sreu_pkg::ST_MEMWR;
                end else begin
                    unique case (op_reg)
                        sreu_pkg::OP_NOP, sreu_pkg::OP_SMUL, sreu_pkg::OP_SMOD,
                        sreu_pkg::OP_SDIV, sreu_pkg::OP_INT, sreu_pkg::OP_RINT,
                        sreu_pkg::OP_POPI, sreu_pkg::OP_PSHI, sreu_pkg::OP_CSR: ;
                        sreu_pkg::OP_SMULI, sreu_pkg::OP_SMODI, sreu_pkg::OP_SDIVI,
                        sreu_pkg::OP_JSME, sreu_pkg::OP_JSNE, sreu_pkg::OP_JSLT,
                        sreu_pkg::OP_JSGT: onpc_next = npc4;
                        sreu_pkg::OP_ADD, sreu_pkg::OP_SUB, sreu_pkg::OP_AND,
                        sreu_pkg::OP_ORR, sreu_pkg::OP_XOR, sreu_pkg::OP_NOT,
                        sreu_pkg::OP_NEG, sreu_pkg::OP_LSL, sreu_pkg::OP_LSR,
                        sreu_pkg::OP_MUL, sreu_pkg::OP_MOV: begin
                            owr_next = 1'b1;
                            oreg_next = d_reg;
                            unique case (op_reg)
                                sreu_pkg::OP_ADD: oval_next = rs_q + rd_q;
                                sreu_pkg::OP_SUB: oval_next = rs_q - rd_q;
                                sreu_pkg::OP_AND: oval_next = rs_q & rd_q;
                                sreu_pkg::OP_ORR: oval_next = rs_q | rd_q;
                                sreu_pkg::OP_XOR: oval_next = rs_q ^ rd_q;
                                sreu_pkg::OP_NOT: oval_next = ~rs_q;
                                sreu_pkg::OP_NEG: oval_next = ~rs_q + 32'd1;
                                sreu_pkg::OP_LSL: oval_next = (|sh_amt_rd[31:5]) ? '0
                                                            : rs_q << sh_amt_rd[4:0];
                                sreu_pkg::OP_LSR: oval_next = (|sh_amt_rd[31:5]) ? '0
                                                            : rs_q >> sh_amt_rd[4:0];
                                sreu_pkg::OP_MUL: oval_next = mprod[31:0];
                                default: oval_next = rs_q;
                            endcase
                        end
                        sreu_pkg::OP_ADDI, sreu_pkg::OP_SUBI, sreu_pkg::OP_ANDI,
                        sreu_pkg::OP_ORRI, sreu_pkg::OP_XORI, sreu_pkg::OP_LSLI,
                        sreu_pkg::OP_LSRI, sreu_pkg::OP_MULI: begin
                            onpc_next = npc4;
                            owr_next = 1'b1;
                            oreg_next = d_reg;
                            unique case (op_reg)
                                sreu_pkg::OP_ADDI: oval_next = rs_q + uim;
                                sreu_pkg::OP_SUBI: oval_next = rs_q - uim;
                                sreu_pkg::OP_ANDI: oval_next = rs_q & uim;
                                sreu_pkg::OP_ORRI: oval_next = rs_q | uim;
                                sreu_pkg::OP_XORI: oval_next = rs_q ^ uim;
                                sreu_pkg::OP_LSLI: oval_next = (|im_reg[15:5]) ? '0
                                                             : rs_q << im_reg[4:0];
                                sreu_pkg::OP_LSRI: oval_next = (|im_reg[15:5]) ? '0
                                                             : rs_q >> im_reg[4:0];
                                default: oval_next = mprod[31:0];
                            endcase
                        end
                        sreu_pkg::OP_MOD, sreu_pkg::OP_DIV,
                        sreu_pkg::OP_MODI, sreu_pkg::OP_DIVI: begin
                            if (op_reg[6]) begin
                                onpc_next = npc4;
                            end
                            owr_next = 1'b1;
                            oreg_next = d_reg;
                            is_mod_next = (op_reg == sreu_pkg::OP_MOD)
                                       || (op_reg == sreu_pkg::OP_MODI);
                            if (dreq.divisor == '0) begin
                                odz_next = 1'b1;
                                oval_next = is_mod_next ? rs_q : 32'hffffffff;
                            end else begin
                                dreq.start = 1'b1;
                                state_next = sreu_pkg::ST_DIV;
                            end
                        end
                        sreu_pkg::OP_JMP: onpc_next = npcb;
                        sreu_pkg::OP_JME: onpc_next = (rs_q == rd_q) ? npcb : npc4;
                        sreu_pkg::OP_JNE: onpc_next = (rs_q != rd_q) ? npcb : npc4;
                        sreu_pkg::OP_JLT: onpc_next = (rs_q < rd_q) ? npcb : npc4;
                        sreu_pkg::OP_JGT: onpc_next = (rs_q > rd_q) ? npcb : npc4;
                        sreu_pkg::OP_CAL: begin
                            owr_next = 1'b1;
                            oreg_next = sreu_pkg::LINK_REG;
                            oval_next = npc4;
                            onpc_next = pc_reg + pl;
                        end
                        sreu_pkg::OP_CAR: begin
                            owr_next = 1'b1;
                            oreg_next = sreu_pkg::LINK_REG;
                            oval_next = npc2;
                            onpc_next = (s_reg == sreu_pkg::LINK_REG) ? npc2 : rs_q;
                        end
                        sreu_pkg::OP_LEA: begin
                            onpc_next = npc4;
                            owr_next = 1'b1;
                            oreg_next = d_reg;
                            oval_next = npcb;
                        end
                        sreu_pkg::OP_RET: onpc_next = r15_q;
                        default: begin
                            oinv_next = 1'b1;
                            onpc_next = pc_reg;
                        end
                    endcase
                end
            end
            sreu_pkg::ST_MEMRD: begin
                // address presented; data returns next cycle
                dm_addr = addr_reg[AW-1:0];
                state_next = sreu_pkg::ST_MEMWAIT;
            end
            sreu_pkg::ST_MEMWAIT: begin
                acc_next = {acc_reg[23:0], dm_q};
                addr_next = addr_reg + 32'd1;
                bi_next = bi_reg + 3'd1;
                if (bi_reg + 3'd1 == nb_next) begin
                    oval_next = {acc_reg[23:0], dm_q};
                    if (ld_sx && nb_next == 3'd1) begin
                        oval_next = {{24{dm_q[7]}}, dm_q};
                    end else if (ld_sx) begin
                        oval_next = {{16{acc_reg[7]}}, acc_reg[7:0], dm_q};
                    end
                    state_next = sreu_pkg::ST_DONE;
                end else begin
                    state_next = sreu_pkg::ST_MEMRD;
                end
            end
            sreu_pkg::ST_MEMWR: begin
                dm_we = 1'b1;
                st_next = {st_reg[23:0], 8'd0};
                addr_next = addr_reg + 32'd1;
                bi_next = bi_reg + 3'd1;
                if (bi_reg + 3'd1 == nb_next) begin
                    state_next = sreu_pkg::ST_DONE;
                end
            end
            sreu_pkg::ST_DIV: begin
                if (drsp.done) begin
                    oval_next = is_mod_reg ? drsp.remainder : drsp.quotient;
                    state_next = sreu_pkg::ST_DONE;
                end
            end
            sreu_pkg::ST_DONE: begin
                if (!ov_reg) begin
                    rf_we = owr_reg;
                    pc_next = onpc_reg;
                    ov_next = 1'b1;
                    state_next = sreu_pkg::ST_IDLE;
                end
            end
            default: state_next = sreu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sreu_pkg::ST_IDLE;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            pc_reg      <= '0;
            ov_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
            pc_reg      <= pc_next;
            ov_reg      <= ov_next;
        end
        op_reg   <= op_next;
        s_reg    <= s_next;
        d_reg    <= d_next;
        im_reg   <= im_next;
        addr_reg <= addr_next;
        nb_reg   <= nb_next;
        bi_reg   <= bi_next;
        acc_reg  <= acc_next;
        st_reg   <= st_next;
        onpc_reg <= onpc_next;
        owr_reg  <= owr_next;
        oreg_reg <= oreg_next;
        oval_reg <= oval_next;
        omw_reg  <= omw_next;
        oinv_reg <= oinv_next;
        odz_reg  <= odz_next;
        is_mod_reg <= is_mod_next;
    end

    assign m_valid          = ov_reg;
    assign m_next_pc        = onpc_reg;
    assign m_reg_written    = owr_reg;
    assign m_written_reg    = oreg_reg;
    assign m_written_value  = oval_reg;
    assign m_mem_written    = omw_reg;
    assign m_invalid_op     = oinv_reg;
    assign m_divide_by_zero = odz_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == sreu_pkg::ST_IDLE && !clr_reg))
        else $error("ready outside idle");
    a_inv_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_invalid_op) |-> (!m_reg_written && !m_mem_written))
        else $error("invalid op wrote state");
    a_pc_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ov_reg) |-> pc_reg == onpc_reg) else $error("pc not committed");
    a_dz_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_by_zero) |-> m_reg_written)
        else $error("divide by zero without write");

endmodule
